[rtl/ldc_pkg.sv]
// Shared types, constants and scan tables for the luma DC inverse Hadamard block.
// No dependencies; used by every module of the block.
package ldc_pkg;

	localparam int CoefW  = 16;
	localparam int MatW   = 20;
	localparam int ProdW  = 26;
	localparam int ValW   = 32;
	localparam int IdxW   = 4;
	localparam int QpW    = 6;
	localparam int ScaleW = 5;
	localparam int ShW    = 4;

	localparam logic [QpW-1:0] QpShiftSplit = QpW'(12);
	localparam logic [IdxW-1:0] LastIdx     = IdxW'(15);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROW,
		ST_COL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic            load;
		logic [IdxW-1:0] load_idx;
		logic            last_load;
		logic            row_pass;
		logic            col_pass;
		logic            emit;
		logic [IdxW-1:0] emit_idx;
	} cmd_t;

	function automatic logic [IdxW-1:0] zigzag_pos(input logic [IdxW-1:0] idx);
		logic [IdxW-1:0] r;
		case (idx)
			4'd0:    r = 4'd0;
			4'd1:    r = 4'd1;
			4'd2:    r = 4'd4;
			4'd3:    r = 4'd8;
			4'd4:    r = 4'd5;
			4'd5:    r = 4'd2;
			4'd6:    r = 4'd3;
			4'd7:    r = 4'd6;
			4'd8:    r = 4'd9;
			4'd9:    r = 4'd12;
			4'd10:   r = 4'd13;
			4'd11:   r = 4'd10;
			4'd12:   r = 4'd7;
			4'd13:   r = 4'd11;
			4'd14:   r = 4'd14;
			default: r = 4'd15;
		endcase
		return r;
	endfunction

	function automatic logic [IdxW-1:0] block_order(input logic [IdxW-1:0] idx);
		logic [IdxW-1:0] r;
		case (idx)
			4'd0:    r = 4'd0;
			4'd1:    r = 4'd1;
			4'd2:    r = 4'd4;
			4'd3:    r = 4'd5;
			4'd4:    r = 4'd2;
			4'd5:    r = 4'd3;
			4'd6:    r = 4'd6;
			4'd7:    r = 4'd7;
			4'd8:    r = 4'd8;
			4'd9:    r = 4'd9;
			4'd10:   r = 4'd12;
			4'd11:   r = 4'd13;
			4'd12:   r = 4'd10;
			4'd13:   r = 4'd11;
			4'd14:   r = 4'd14;
			default: r = 4'd15;
		endcase
		return r;
	endfunction

	function automatic logic [ScaleW-1:0] level_scale(input logic [2:0] rem);
		logic [ScaleW-1:0] r;
		case (rem)
			3'd0:    r = 5'd10;
			3'd1:    r = 5'd11;
			3'd2:    r = 5'd13;
			3'd3:    r = 5'd14;
			3'd4:    r = 5'd16;
			default: r = 5'd18;
		endcase
		return r;
	endfunction

endpackage

[rtl/luma_dc_inverse_hadamard_dequant.sv]
// Results come one per cycle once the sixteenth coefficient is in and both passes are done.
// A block of 16 coefficients takes 16 loads, a row pass, a column pass and 16 emits.
// No new block is loaded until the emit sweep through the coefficient matrix is done; results cannot be stalled.
// Reset (arst_n low) returns to loading with the coefficient count at zero; matrix is not cleared.
// Depends on ldc_pkg, ldc_ctrl and ldc_datapath.
module luma_dc_inverse_hadamard_dequant (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [ldc_pkg::CoefW-1:0]   coefficient,
	input  logic        [ldc_pkg::QpW-1:0]     quant_param,
	output logic                               result_valid,
	output logic signed [ldc_pkg::ValW-1:0]    dc_value,
	output logic        [ldc_pkg::IdxW-1:0]    block_index,
	output logic                               last_result
);

	ldc_pkg::cmd_t cmd;

	ldc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	ldc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.coefficient  (coefficient),
		.quant_param  (quant_param),
		.dc_value     (dc_value),
		.block_index  (block_index),
		.last_result  (last_result),
		.result_valid (result_valid)
	);

endmodule

[rtl/ldc_ctrl.sv]
// Sequencer for the luma DC block: load, row pass, column pass, emit.
// Depends on ldc_pkg; drives the command struct of ldc_datapath.
module ldc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output ldc_pkg::cmd_t cmd
);

	ldc_pkg::state_t state_q, state_nxt;
	logic [ldc_pkg::IdxW-1:0] count_q;
	logic accept;

	assign accept = start && (state_q == ldc_pkg::ST_LOAD);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ldc_pkg::ST_LOAD: begin
				if (accept && count_q == ldc_pkg::LastIdx) state_nxt = ldc_pkg::ST_ROW;
			end
			ldc_pkg::ST_ROW:  state_nxt = ldc_pkg::ST_COL;
			ldc_pkg::ST_COL:  state_nxt = ldc_pkg::ST_EMIT;
			ldc_pkg::ST_EMIT: begin
				if (count_q == ldc_pkg::LastIdx) state_nxt = ldc_pkg::ST_LOAD;
			end
			default: state_nxt = ldc_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		busy          = 1'b1;
		cmd.load      = 1'b0;
		cmd.load_idx  = count_q;
		cmd.last_load = 1'b0;
		cmd.row_pass  = 1'b0;
		cmd.col_pass  = 1'b0;
		cmd.emit      = 1'b0;
		cmd.emit_idx  = count_q;
		case (state_q)
			ldc_pkg::ST_LOAD: begin
				busy          = 1'b0;
				cmd.load      = accept;
				cmd.last_load = accept && (count_q == ldc_pkg::LastIdx);
			end
			ldc_pkg::ST_ROW:  cmd.row_pass = 1'b1;
			ldc_pkg::ST_COL:  cmd.col_pass = 1'b1;
			ldc_pkg::ST_EMIT: cmd.emit = 1'b1;
			default:          busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ldc_pkg::ST_LOAD;
			count_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept || state_q == ldc_pkg::ST_EMIT) count_q <= count_q + 1'b1;
		end
	end

endmodule

[rtl/ldc_datapath.sv]
// Coefficient matrix, in-place Hadamard butterflies and two-stage dequantiser.
// Depends on ldc_pkg; commanded by ldc_ctrl.
module ldc_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ldc_pkg::cmd_t                      cmd,
	input  logic signed [ldc_pkg::CoefW-1:0]   coefficient,
	input  logic        [ldc_pkg::QpW-1:0]     quant_param,
	output logic signed [ldc_pkg::ValW-1:0]    dc_value,
	output logic        [ldc_pkg::IdxW-1:0]    block_index,
	output logic                               last_result,
	output logic                               result_valid
);

	logic signed [ldc_pkg::MatW-1:0] mat_q [16];
	logic signed [ldc_pkg::MatW-1:0] row_res [16];
	logic signed [ldc_pkg::MatW-1:0] col_res [16];

	logic [ldc_pkg::ScaleW-1:0] scale_q;
	logic [ldc_pkg::ShW-1:0]    shift_q;
	logic                       left_q;

	logic [11:0] qp_mul;
	logic [3:0]  qp_div;
	logic [2:0]  qp_rem6;
	logic        qp_ge12;

	logic signed [ldc_pkg::ProdW-1:0] prod_s1;
	logic        [ldc_pkg::IdxW-1:0]  idx_s1;
	logic                             valid_s1;

	logic signed [ldc_pkg::ValW-1:0]    ext;
	logic signed [ldc_pkg::ProdW:0]     rsum;
	logic signed [ldc_pkg::ProdW:0]     rval;
	logic        [ldc_pkg::ProdW:0]     rbias;
	logic signed [ldc_pkg::ValW-1:0]    deq;

	// quotient by six through a reciprocal, exact for six-bit values
	assign qp_mul  = 12'(quant_param) * 12'd43;
	assign qp_div  = qp_mul[11:8];
	assign qp_rem6 = 3'(quant_param - 6'(qp_div) * 6'd6);
	assign qp_ge12 = quant_param >= ldc_pkg::QpShiftSplit;

	always_comb begin
		logic signed [ldc_pkg::MatW-1:0] a, b, d, e;
		for (int r = 0; r < 4; r++) begin
			a = mat_q[4*r]     + mat_q[4*r + 1];
			b = mat_q[4*r + 2] + mat_q[4*r + 3];
			d = mat_q[4*r]     - mat_q[4*r + 1];
			e = mat_q[4*r + 2] - mat_q[4*r + 3];
			row_res[4*r]     = a + b;
			row_res[4*r + 1] = a - b;
			row_res[4*r + 2] = d - e;
			row_res[4*r + 3] = d + e;
		end
	end

	always_comb begin
		logic signed [ldc_pkg::MatW-1:0] a, b, d, e;
		for (int c = 0; c < 4; c++) begin
			a = mat_q[c]     + mat_q[4 + c];
			b = mat_q[8 + c] + mat_q[12 + c];
			d = mat_q[c]     - mat_q[4 + c];
			e = mat_q[8 + c] - mat_q[12 + c];
			col_res[c]      = a + b;
			col_res[4 + c]  = a - b;
			col_res[8 + c]  = d - e;
			col_res[12 + c] = d + e;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) mat_q[ldc_pkg::zigzag_pos(cmd.load_idx)] <= ldc_pkg::MatW'(coefficient);
		else if (cmd.row_pass) mat_q <= row_res;
		else if (cmd.col_pass) mat_q <= col_res;
	end

	always_ff @(posedge clk) begin
		if (cmd.last_load) begin
			scale_q <= ldc_pkg::level_scale(qp_rem6);
			left_q  <= qp_ge12;
			shift_q <= qp_ge12 ? qp_div - 4'd2 : 4'd2 - qp_div;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mat_q[cmd.emit_idx] * $signed({1'b0, scale_q});
		idx_s1  <= cmd.emit_idx;
	end

	assign ext   = ldc_pkg::ValW'(prod_s1);
	assign rbias = (ldc_pkg::ProdW+1)'(1) << (shift_q - 4'd1);
	assign rsum  = (ldc_pkg::ProdW+1)'(prod_s1) + $signed(rbias);
	assign rval  = rsum >>> shift_q;
	assign deq   = left_q ? (ext <<< shift_q) : ldc_pkg::ValW'(rval);

	always_ff @(posedge clk) begin
		dc_value    <= deq;
		block_index <= ldc_pkg::block_order(idx_s1);
		last_result <= valid_s1 && (idx_s1 == ldc_pkg::LastIdx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			valid_s1     <= cmd.emit;
			result_valid <= valid_s1;
		end
	end

endmodule

[rtl/ldc_checker.sv]
// Port-level checks on the result burst of the luma DC block, bound to the top level.
// Depends on ldc_pkg and luma_dc_inverse_hadamard_dequant.
module ldc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          result_valid,
	input logic [ldc_pkg::IdxW-1:0]      block_index,
	input logic                          last_result
);

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_result |-> result_valid)
		else $error("last_result without result_valid");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_result |=> result_valid)
		else $error("result burst broken");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_result |=> !result_valid)
		else $error("result after last_result");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> block_index == '0)
		else $error("burst does not start at block zero");

	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_result |-> block_index == ldc_pkg::LastIdx)
		else $error("last result not at block fifteen");

endmodule

bind luma_dc_inverse_hadamard_dequant ldc_checker u_ldc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.block_index  (block_index),
	.last_result  (last_result)
);
